// ----- src/ola_pkg.sv -----
// Package for the ordered list block: operation and status codes, default
// capacity, and the packed beat types of the command and result channels.
// No dependencies.
package ola_pkg;

  localparam int OLA_CAPACITY = 16;
  localparam int DATA_W       = 32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] item;
    logic [1:0]               status;
    logic                     last;
  } out_beat_t;

  // Per-cycle commands from the sequencer to the row of cells.
  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctrl_t;

endpackage

// ----- src/ordered_list_append_delete.sv -----
// Ordered list with append, delete-first-match and read out, kept in a row
// of cells. An append, or a delete or read out on an empty list, gives its
// single result beat in the cycle after it is accepted, and busy stays low.
// A delete or read out of N entries rotates the list once around the chain,
// and busy is high while the rotation runs.
// Read out beats come one per cycle; the receiver cannot stall them.
// Reset (rst_n low, synchronous) empties the list and drops pending results.
module ordered_list_append_delete
  import ola_pkg::*;
#(
  parameter int CAPACITY = OLA_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_data,
  output logic      out_valid,
  output out_beat_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Sequencer states: idle, or rotating the list through the head cell.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROT  = 1'b1;

  logic                     state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         steps_r, steps_nxt;
  logic                     is_del_r, is_del_nxt;
  logic                     found_r, found_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_beat_t                out_data_r, out_data_nxt;

  chain_ctrl_t              ctrl;
  logic [IDX_W-1:0]         wr_idx;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] head;
  logic                     accept;
  logic                     drop;
  logic [CNT_W-1:0]         count_m1;

  ola_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .head    (head)
  );

  assign busy     = (state_r == ST_ROT);
  assign accept   = start && !busy;
  assign count_m1 = count_r - CNT_W'(1);

  // During a rotation the head entry leaves the chain each cycle. It goes
  // back in behind the remaining entries unless it is the first match of a
  // delete, in which case it is dropped and the list shrinks by one. After
  // as many steps as the list held, the order is back where it started.
  assign drop = is_del_r && !found_r && (head == key_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    is_del_nxt    = is_del_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '{item: '0, status: STAT_OK, last: 1'b1};
    ctrl          = '{shift: 1'b0, load: 1'b0};
    wr_idx        = count_r[IDX_W-1:0];
    wr_data       = in_data.value;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.op)
            OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(CAPACITY)) begin
                out_data_nxt.status = STAT_FULL;
              end else begin
                // The tail slot is the cell just past the current entries.
                ctrl.load = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_DELETE, OP_READ: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = STAT_EMPTY;
              end else begin
                state_nxt  = ST_ROT;
                steps_nxt  = count_r;
                is_del_nxt = (in_data.op == OP_DELETE);
                found_nxt  = 1'b0;
                key_nxt    = in_data.value;
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROT: begin
        ctrl.shift = 1'b1;
        ctrl.load  = !drop;
        wr_idx     = count_m1[IDX_W-1:0];
        wr_data    = head;
        steps_nxt  = steps_r - CNT_W'(1);
        if (drop) begin
          found_nxt = 1'b1;
          count_nxt = count_m1;
        end
        if (is_del_r) begin
          // A delete reports once, when the rotation is complete.
          if (steps_r == CNT_W'(1)) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = (found_r || drop) ? STAT_OK : STAT_NOT_FOUND;
          end
        end else begin
          // A read out sends the head entry as it passes by.
          out_valid_nxt     = 1'b1;
          out_data_nxt.item = head;
          out_data_nxt.last = (steps_r == CNT_W'(1));
        end
        if (steps_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      is_del_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      is_del_r    <= is_del_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The key and the result payload need no reset.
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/ola_cell.sv -----
// One storage cell of the ordered list chain.
// Depends on ola_pkg for the data width.
module ola_cell
  import ola_pkg::*;
(
  input  logic                     clk,
  input  logic                     shift_en,
  input  logic                     load_en,
  input  logic signed [DATA_W-1:0] load_data,
  input  logic signed [DATA_W-1:0] next_data,
  output logic signed [DATA_W-1:0] data_q
);

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  // A load overrides the shift from the right-hand neighbor.
  always_comb begin
    value_nxt = value_r;
    if (load_en) begin
      value_nxt = load_data;
    end else if (shift_en) begin
      value_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign data_q = value_r;

endmodule

// ----- src/ola_chain.sv -----
// Row of list cells, head at cell 0; every cell shifts toward the head and
// one addressed cell may load. Depends on ola_pkg and ola_cell.
module ola_chain
  import ola_pkg::*;
#(
  parameter int CAPACITY = OLA_CAPACITY,
  localparam int IDX_W   = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  chain_ctrl_t              ctrl,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic signed [DATA_W-1:0] wr_data,
  output logic signed [DATA_W-1:0] head
);

  logic signed [DATA_W-1:0] cell_q [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] right;
    if (i < CAPACITY - 1) begin : g_mid
      assign right = cell_q[i+1];
    end else begin : g_end
      assign right = cell_q[i];
    end

    ola_cell u_cell (
      .clk       (clk),
      .shift_en  (ctrl.shift),
      .load_en   (ctrl.load && (wr_idx == IDX_W'(i))),
      .load_data (wr_data),
      .next_data (right),
      .data_q    (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

// ----- tb/ordered_list_checker.sv -----
`timescale 1ns / 100ps
// Checker for the ordered list block: watches the command and result channels,
// keeps its own copy of the list and compares every result beat in order.
// Depends on ola_pkg for the beat types and the operation and status codes.
module ordered_list_checker
  import ola_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending
);

  // Shadow copy of the list, head at index 0.
  logic signed [DATA_W-1:0] list_vals [OLA_CAPACITY];
  int unsigned              list_len;

  out_beat_t awaited_beats[$];
  int        errors;

  assign fail_count = errors;

  function automatic out_beat_t make_beat(logic signed [DATA_W-1:0] item,
                                          logic [1:0] status, logic last);
    out_beat_t b;
    b.item   = item;
    b.status = status;
    b.last   = last;
    return b;
  endfunction

  // Apply one accepted command to the shadow list and queue the beats it causes.
  task automatic apply_command(input in_beat_t cmd);
    int hit;
    hit = -1;
    case (cmd.op)
      OP_APPEND: begin
        if (list_len >= OLA_CAPACITY) begin
          awaited_beats.push_back(make_beat('0, STAT_FULL, 1'b1));
        end else begin
          list_vals[list_len] = cmd.value;
          list_len++;
          awaited_beats.push_back(make_beat('0, STAT_OK, 1'b1));
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          awaited_beats.push_back(make_beat('0, STAT_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (hit < 0 && list_vals[i] == cmd.value) hit = i;
          end
          if (hit < 0) begin
            awaited_beats.push_back(make_beat('0, STAT_NOT_FOUND, 1'b1));
          end else begin
            for (int j = hit; j + 1 < list_len; j++) list_vals[j] = list_vals[j + 1];
            list_len--;
            awaited_beats.push_back(make_beat('0, STAT_OK, 1'b1));
          end
        end
      end
      OP_READ: begin
        if (list_len == 0) begin
          awaited_beats.push_back(make_beat('0, STAT_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < list_len; i++) begin
            awaited_beats.push_back(make_beat(list_vals[i], STAT_OK, i + 1 == list_len));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    if (awaited_beats.size() == 0) begin
      $error("result beat with nothing awaited: item %0d status %0d last %0d",
             got.item, got.status, got.last);
      errors++;
    end else begin
      want = awaited_beats.pop_front();
      if (got.item !== want.item) begin
        $error("item mismatch: expected %0d, actual %0d", want.item, got.item);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    end
  endtask

  initial begin
    errors   = 0;
    list_len = 0;
    pending  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      awaited_beats.delete();
    end else begin
      if (out_valid) check_beat(out_data);
      if (start && !busy) apply_command(in_data);
    end
    pending <= awaited_beats.size();
  end

endmodule

// ----- tb/ordered_list_append_delete_test.sv -----
`timescale 1ns / 100ps
// Top of the testbench for the ordered list block: clock, reset, command
// stimulus, watchdog and verdict. Depends on ola_pkg, the block itself and
// ordered_list_checker, which does all prediction and comparison.
module ordered_list_append_delete_test;
  import ola_pkg::*;

  // Cycles with neither an accepted command nor a result beat before the run
  // is declared hung. The longest legal quiet stretch is a delete rotating a
  // full list followed by the longest sender gap, so this is generous.
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 80;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  int        idle_cycles;

  // Burst bookkeeping of the command sender.
  int burst_left;
  int gap;

  // Small pool of values reused within a phase, so that deletes hit stored
  // entries and duplicates appear regularly.
  logic signed [DATA_W-1:0] value_pool [8];

  ordered_list_append_delete u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  ordered_list_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: any accepted command or result beat counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one command beat and hold it until the block takes it. Commands
  // come in bursts; before each burst the sender may drop start for a random
  // number of cycles. Start stays high across back-to-back beats, so it gets
  // only one assignment per edge.
  task automatic send(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
    in_beat_t b;
    b.op    = op;
    b.value = v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= b;
    // The beat is taken at the first edge where busy was low.
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait until the checker has seen every awaited beat.
  // The pending count is registered in the same step that applies each accepted
  // command, so it already covers the last one when it is read.
  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return value_pool[$urandom_range(0, 7)];
    if (r < 60) return 32'sh8000_0000;
    if (r < 65) return 32'sh7fff_ffff;
    return $urandom;
  endfunction

  initial begin
    int counted;
    int pct;
    int append_pct;
    int delete_pct;
    logic [1:0] op;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    burst_left  = 0;
    gap         = 0;
    idle_cycles = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. First every command on an empty list, including the
    // unused code, which must cause no beat at all.
    send(OP_READ, 32'sd0);
    send(OP_DELETE, 32'sd7);
    send(OP_NONE, 32'sd0);

    // Fill the list to capacity with the value extremes, alternating bit
    // patterns and a duplicate of the largest positive value.
    send(OP_APPEND, 32'sh8000_0000);
    send(OP_APPEND, 32'sh7fff_ffff);
    send(OP_APPEND, -32'sd1);
    send(OP_APPEND, 32'sd0);
    send(OP_APPEND, 32'sd1);
    send(OP_APPEND, 32'sh7fff_ffff);
    send(OP_APPEND, 32'sh5555_5555);
    send(OP_APPEND, 32'shaaaa_aaaa);
    repeat (OLA_CAPACITY - 8) send(OP_APPEND, $urandom);

    // Append to a full list, then read out a full list.
    send(OP_APPEND, 32'sh1234_5678);
    send(OP_READ, -32'sd1);

    // A key that differs from a stored entry in one bit is not a match, and
    // of two equal entries only the one nearest the head goes away.
    send(OP_DELETE, 32'sh7fff_fffe);
    send(OP_DELETE, 32'sh7fff_ffff);
    send(OP_NONE, -32'sd1);
    send(OP_READ, 32'sd0);

    // Let every directed beat arrive before the random part starts.
    wait_drained();

    // Random part in four phases with different operation mixes: the first
    // and last lean on appends so the list runs full, the second drains it
    // with deletes so empty and not-found cases come up again.
    for (int phase = 0; phase < 4; phase++) begin
      for (int k = 0; k < 8; k++) value_pool[k] = $urandom;
      case (phase)
        0:       begin append_pct = 60; delete_pct = 25; end
        1:       begin append_pct = 30; delete_pct = 55; end
        2:       begin append_pct = 45; delete_pct = 40; end
        default: begin append_pct = 70; delete_pct = 15; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pct = $urandom_range(0, 99);
        if ($urandom_range(0, 24) == 0) begin
          op = OP_NONE;
        end else if (pct < append_pct) begin
          op = OP_APPEND;
        end else if (pct < append_pct + delete_pct) begin
          op = OP_DELETE;
        end else begin
          op = OP_READ;
        end
        // Ignored commands do not count toward the phase length.
        if (op != OP_NONE) counted++;
        send(op, (op == OP_READ || op == OP_NONE) ? $urandom : pick_value());
      end
      wait_drained();
    end

    // Allow for the longest read out before the verdict.
    repeat (OLA_CAPACITY + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      if (pending != 0) $error("%0d result beats never arrived", pending);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ola_pkg.sv
src/ola_cell.sv
src/ola_chain.sv
src/ordered_list_append_delete.sv
tb/ordered_list_checker.sv
tb/ordered_list_append_delete_test.sv
